// ----- design/rmte_pkg.sv -----
// Shared types, constants and helpers for the rotation matrix to Euler angle unit.
// No dependencies; every design file of the block refers to this package by scoped names.
package rmte_pkg;

    localparam int ANGLE_ITERATIONS_DEFAULT = 16;
    localparam int MAX_STAGES  = 32;
    localparam int SQRT_STEPS  = 16;
    localparam int SUM_W       = 2 * SQRT_STEPS;
    localparam int REM_W       = SQRT_STEPS + 3;
    localparam int ELEM_W      = 16;
    localparam int OPND_W      = ELEM_W + 1;
    localparam int CORDIC_W    = 28;
    localparam int ANGLE_W     = 25;
    localparam int THR_W       = 15;
    localparam int THR_RESET   = 1;

    localparam logic signed [ANGLE_W-1:0] PI_Q20      = 25'sd3294199;
    localparam logic signed [18:0]        YAW_LIMIT   = 19'sd25736;
    localparam logic signed [18:0]        PITCH_LIMIT = 19'sd12868;

    typedef struct packed {
        logic signed [ELEM_W-1:0] r00;
        logic signed [ELEM_W-1:0] r10;
        logic signed [ELEM_W-1:0] r20;
        logic signed [ELEM_W-1:0] r11;
        logic signed [ELEM_W-1:0] r12;
        logic signed [ELEM_W-1:0] r21;
        logic signed [ELEM_W-1:0] r22;
    } mat_t;

    typedef struct packed {
        logic [REM_W-1:0]      rem;
        logic [SQRT_STEPS-1:0] root;
        logic [SUM_W-1:0]      v;
    } sqrt_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ANGLE_W-1:0]  z;
        logic                       zero;
    } lane_t;

    // atan(2^-i) in Q.20 radians
    function automatic logic signed [ANGLE_W-1:0] atan_q20(input int i);
        logic signed [ANGLE_W-1:0] a;
        case (i)
            0:  a = 25'sd823550;
            1:  a = 25'sd486170;
            2:  a = 25'sd256879;
            3:  a = 25'sd130396;
            4:  a = 25'sd65451;
            5:  a = 25'sd32757;
            6:  a = 25'sd16383;
            7:  a = 25'sd8192;
            8:  a = 25'sd4096;
            9:  a = 25'sd2048;
            10: a = 25'sd1024;
            11: a = 25'sd512;
            12: a = 25'sd256;
            13: a = 25'sd128;
            14: a = 25'sd64;
            15: a = 25'sd32;
            16: a = 25'sd16;
            17: a = 25'sd8;
            18: a = 25'sd4;
            19: a = 25'sd2;
            20: a = 25'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Scale operands by 256 and fold the left half plane onto the right one.
    function automatic lane_t launch(input logic signed [OPND_W-1:0] y,
                                     input logic signed [OPND_W-1:0] x);
        lane_t l;
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        xs = {{(CORDIC_W-OPND_W-8){x[OPND_W-1]}}, x, 8'b0};
        ys = {{(CORDIC_W-OPND_W-8){y[OPND_W-1]}}, y, 8'b0};
        l.zero = (x == '0) && (y == '0);
        if (x[OPND_W-1])
        begin
            l.z = y[OPND_W-1] ? -PI_Q20 : PI_Q20;
            l.x = -xs;
            l.y = -ys;
        end
        else
        begin
            l.z = '0;
            l.x = xs;
            l.y = ys;
        end
        return l;
    endfunction

    // Round Q.20 to Q2.13 half up and clamp; a zero vector gives zero.
    function automatic logic signed [18:0] finish(input lane_t l,
                                                  input logic signed [18:0] lim);
        logic signed [ANGLE_W:0] s;
        logic signed [18:0]      q;
        s = {l.z[ANGLE_W-1], l.z} + 26'sd64;
        q = 19'(s >>> 7);
        if (l.zero)
            q = '0;
        else if (q > lim)
            q = lim;
        else if (q < -lim)
            q = -lim;
        return q;
    endfunction

endpackage

// ----- design/rmte_sqrt_cell.sv -----
// One digit step of the integer square root pipeline, carrying the matrix alongside.
// Depends on rmte_pkg.
module rmte_sqrt_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           in_valid,
    input  rmte_pkg::sqrt_t in_sq,
    input  rmte_pkg::mat_t  in_mat,
    output logic           out_valid,
    output rmte_pkg::sqrt_t out_sq,
    output rmte_pkg::mat_t  out_mat
);

    logic valid_reg;
    rmte_pkg::sqrt_t sq_reg, sq_next;
    rmte_pkg::mat_t  mat_reg;
    logic [rmte_pkg::REM_W-1:0] rem_sh;
    logic [rmte_pkg::REM_W-1:0] trial;

    always_comb
    begin
        rem_sh  = {in_sq.rem[rmte_pkg::REM_W-3:0], in_sq.v[rmte_pkg::SUM_W-1 -: 2]};
        trial   = {1'b0, in_sq.root, 2'b01};
        sq_next.v = {in_sq.v[rmte_pkg::SUM_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            sq_next.rem  = rem_sh - trial;
            sq_next.root = {in_sq.root[rmte_pkg::SQRT_STEPS-2:0], 1'b1};
        end
        else
        begin
            sq_next.rem  = rem_sh;
            sq_next.root = {in_sq.root[rmte_pkg::SQRT_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_reg  <= sq_next;
            mat_reg <= in_mat;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_mat   = mat_reg;

endmodule

// ----- design/rmte_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation with a fixed shift.
// Depends on rmte_pkg.
module rmte_cordic_cell
#(
    parameter int STAGE = 0
)
(
    input  logic           clk,
    input  logic           advance,
    input  rmte_pkg::lane_t in_lane,
    output rmte_pkg::lane_t out_lane
);

    rmte_pkg::lane_t lane_reg, lane_next;

    always_comb
    begin
        lane_next.zero = in_lane.zero;
        if (!in_lane.y[rmte_pkg::CORDIC_W-1])
        begin
            lane_next.x = in_lane.x + (in_lane.y >>> STAGE);
            lane_next.y = in_lane.y - (in_lane.x >>> STAGE);
            lane_next.z = in_lane.z + rmte_pkg::atan_q20(STAGE);
        end
        else
        begin
            lane_next.x = in_lane.x - (in_lane.y >>> STAGE);
            lane_next.y = in_lane.y + (in_lane.x >>> STAGE);
            lane_next.z = in_lane.z - rmte_pkg::atan_q20(STAGE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            lane_reg <= lane_next;
    end

    assign out_lane = lane_reg;

endmodule

// ----- design/rotation_matrix_to_euler_angles_unit.sv -----
// Top level: rotation matrix to Z-Y-X Euler angles (yaw, pitch, roll).
// Depends on rmte_pkg, rmte_sqrt_cell and rmte_cordic_cell.
//
// The unit takes one matrix word per cycle and returns one angle word per
// matrix, in order. From input to output register a word passes one
// squaring stage, 16 square root digit cells, one compare and CORDIC
// launch stage, one cell per CORDIC iteration and one rounding stage;
// the rows of cells are fully pipelined, so a new word enters every
// cycle. The whole pipe stalls only when the output word is held by
// m_tready low. s_tdata: r00, r10, r20, r11, r12, r21, r22, each signed
// Q1.14. m_tdata: yaw, pitch (15 bit, Q1.13), roll, in radians Q2.13.
// m_tuser flags gimbal lock, in which case roll is zero and yaw comes from
// r11 and r12. Write singular_threshold through cfg_wen/cfg_wdata only while
// no word is in flight.
module rotation_matrix_to_euler_angles_unit
#(
    parameter int ANGLE_ITERATIONS = rmte_pkg::ANGLE_ITERATIONS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // r00, r10, r20, r11, r12, r21, r22
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // yaw, pitch, roll, zero pad bit
    output logic         m_tuser,   // gimbal_locked
    input  logic         cfg_wen,
    input  logic [14:0]  cfg_wdata
);

    localparam int N_STAGES = (ANGLE_ITERATIONS > rmte_pkg::MAX_STAGES) ?
                              rmte_pkg::MAX_STAGES : ANGLE_ITERATIONS;
    localparam int NSQ = rmte_pkg::SQRT_STEPS;

    logic advance;
    logic [rmte_pkg::THR_W-1:0] thr_reg;

    // square stage
    logic                        sq_valid_reg;
    rmte_pkg::mat_t              sq_mat_reg;
    logic [rmte_pkg::SUM_W-1:0]  sq_sum_reg;
    rmte_pkg::mat_t              in_mat;
    logic signed [31:0]          p00, p10;

    // sqrt chain
    logic            sv [0:NSQ];
    rmte_pkg::sqrt_t ss [0:NSQ];
    rmte_pkg::mat_t  sm [0:NSQ];

    // CORDIC lanes: 0 yaw, 1 pitch, 2 roll
    rmte_pkg::lane_t lane_q [0:2][0:N_STAGES];
    logic            cv_reg [0:N_STAGES];
    logic            lk_reg [0:N_STAGES];
    logic [rmte_pkg::SQRT_STEPS-1:0] sy;
    logic            locked;
    logic signed [rmte_pkg::OPND_W-1:0] yy, yx, py, px, ry, rx;

    // output
    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic        out_lock_reg;
    logic signed [18:0] yaw_q, pitch_q, roll_q;

    // Advance the whole pipe unless the output word is stuck.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= rmte_pkg::THR_W'(rmte_pkg::THR_RESET);
        else if (cfg_wen)
            thr_reg <= cfg_wdata;
    end

    // Square and sum r00, r10.
    assign in_mat = '{r00: s_tdata[15:0],  r10: s_tdata[31:16], r20: s_tdata[47:32],
                      r11: s_tdata[63:48], r12: s_tdata[79:64], r21: s_tdata[95:80],
                      r22: s_tdata[111:96]};
    assign p00 = in_mat.r00 * in_mat.r00;
    assign p10 = in_mat.r10 * in_mat.r10;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else if (advance)
            sq_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_mat_reg <= in_mat;
            sq_sum_reg <= $unsigned(p00) + $unsigned(p10);
        end
    end

    // Square root: one result bit per cell.
    assign sv[0] = sq_valid_reg;
    assign ss[0] = '{rem: '0, root: '0, v: sq_sum_reg};
    assign sm[0] = sq_mat_reg;

    genvar k, l;
    generate
        for (k = 0; k < NSQ; k++)
        begin : g_sqrt
            rmte_sqrt_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .in_valid (sv[k]),
                .in_sq    (ss[k]),
                .in_mat   (sm[k]),
                .out_valid(sv[k+1]),
                .out_sq   (ss[k+1]),
                .out_mat  (sm[k+1])
            );
        end
    endgenerate

    // Decide gimbal lock and pick the atan2 operands.
    assign sy     = ss[NSQ].root;
    assign locked = sy < {1'b0, thr_reg};
    assign yy = locked ? -{sm[NSQ].r12[15], sm[NSQ].r12} : {sm[NSQ].r10[15], sm[NSQ].r10};
    assign yx = locked ? {sm[NSQ].r11[15], sm[NSQ].r11} : {sm[NSQ].r00[15], sm[NSQ].r00};
    assign py = -{sm[NSQ].r20[15], sm[NSQ].r20};
    assign px = {1'b0, sy};
    assign ry = {sm[NSQ].r21[15], sm[NSQ].r21};
    assign rx = {sm[NSQ].r22[15], sm[NSQ].r22};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lane_q[0][0] <= rmte_pkg::launch(yy, yx);
            lane_q[1][0] <= rmte_pkg::launch(py, px);
            lane_q[2][0] <= rmte_pkg::launch(ry, rx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N_STAGES; i++)
                cv_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            cv_reg[0] <= sv[NSQ];
            for (int i = 1; i <= N_STAGES; i++)
                cv_reg[i] <= cv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lk_reg[0] <= locked;
            for (int i = 1; i <= N_STAGES; i++)
                lk_reg[i] <= lk_reg[i-1];
        end
    end

    generate
        for (l = 0; l < 3; l++)
        begin : g_lane
            for (k = 0; k < N_STAGES; k++)
            begin : g_stage
                rmte_cordic_cell #(.STAGE(k)) u_cell
                (
                    .clk     (clk),
                    .advance (advance),
                    .in_lane (lane_q[l][k]),
                    .out_lane(lane_q[l][k+1])
                );
            end
        end
    endgenerate

    // Round, clamp and hold the result word.
    assign yaw_q   = rmte_pkg::finish(lane_q[0][N_STAGES], rmte_pkg::YAW_LIMIT);
    assign pitch_q = rmte_pkg::finish(lane_q[1][N_STAGES], rmte_pkg::PITCH_LIMIT);
    assign roll_q  = lk_reg[N_STAGES] ? '0 :
                     rmte_pkg::finish(lane_q[2][N_STAGES], rmte_pkg::YAW_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= cv_reg[N_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {1'b0, roll_q[15:0], pitch_q[14:0], yaw_q[15:0]};
            out_lock_reg <= lk_reg[N_STAGES];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_lock_reg;

    // A locked word always reports zero roll.
    a_roll_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[46:31] == 16'h0000))
        else $error("roll not zero on locked word");

    // Pitch stays within +-pi/2.
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd12868 &&
                      $signed(m_tdata[30:16]) >= -15'sd12868))
        else $error("pitch out of range");

    // Yaw stays within +-pi.
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736 &&
                      $signed(m_tdata[15:0]) >= -16'sd25736))
        else $error("yaw out of range");

    // A zero threshold never locks.
    a_no_lock: assert property (@(posedge clk) disable iff (!rst_n)
        (thr_reg == '0 && cv_reg[0]) |-> !lk_reg[0])
        else $error("lock with zero threshold");

    // The padding bit stays clear.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> (m_tvalid |-> !m_tdata[47]))
        else $error("pad bit set");

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for rotation_matrix_to_euler_angles_unit.
// Drives random and corner matrices, predicts yaw/pitch/roll and the lock flag
// in a local CORDIC model, and compares every output word in order.
`timescale 1ns / 1ps

module tb;

    localparam int ITER        = 16;
    localparam int LATENCY     = 19 + ITER;
    localparam int WATCHDOG    = 2000;
    localparam int PI_Q20_VAL  = 3294199;
    localparam int YAW_LIM     = 25736;
    localparam int PITCH_LIM   = 12868;

    typedef struct packed {
        logic [15:0] yaw;
        logic [14:0] pitch;
        logic [15:0] roll;
        logic        locked;
    } angles_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;    // r00, r10, r20, r11, r12, r21, r22
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;    // yaw, pitch, roll, pad bit
    logic         m_tuser;    // gimbal_locked
    logic         cfg_wen;
    logic [14:0]  cfg_wdata;

    // Local copy of the threshold register, kept in step with each write.
    int unsigned  thr_shadow;
    angles_t      pending_angles[$];
    int           errors;
    int           idle_cycles;

    rotation_matrix_to_euler_angles_unit #(.ANGLE_ITERATIONS(ITER)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // floor(v / 2^s) for signed v
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint atan_step(int i);
        longint t[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                          4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 21) ? t[i] : 0;
    endfunction

    // Vectoring CORDIC atan2 with rounding to Q2.13 and clamping.
    function automatic longint cordic_angle(longint y, longint x, longint lim);
        longint z;
        longint xn;
        longint yn;
        longint q;
        if (x == 0 && y == 0)
            return 0;
        z = 0;
        x = x * 256;
        y = y * 256;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Q20_VAL : -PI_Q20_VAL;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ITER; i++)
        begin
            if (y >= 0)
            begin
                xn = x + floor_shift(y, i);
                yn = y - floor_shift(x, i);
                z = z + atan_step(i);
            end
            else
            begin
                xn = x - floor_shift(y, i);
                yn = y + floor_shift(x, i);
                z = z - atan_step(i);
            end
            x = xn;
            y = yn;
        end
        q = floor_shift(z + 64, 7);
        if (q > lim)
            q = lim;
        if (q < -lim)
            q = -lim;
        return q;
    endfunction

    function automatic angles_t euler_angles(logic signed [15:0] m[7]);
        angles_t a;
        longint  sy;
        longint  yw;
        longint  pt;
        longint  rl;
        sy = int_sqrt(longint'(m[0]) * m[0] + longint'(m[1]) * m[1]);
        a.locked = (sy < thr_shadow);
        pt = cordic_angle(-longint'(m[2]), sy, PITCH_LIM);
        if (a.locked)
        begin
            rl = 0;
            yw = cordic_angle(-longint'(m[4]), m[3], YAW_LIM);
        end
        else
        begin
            rl = cordic_angle(m[5], m[6], YAW_LIM);
            yw = cordic_angle(m[1], m[0], YAW_LIM);
        end
        a.yaw = yw[15:0];
        a.pitch = pt[14:0];
        a.roll = rl[15:0];
        return a;
    endfunction

    // Append one prediction at the tail of the expected list.
    function automatic void add_expected(angles_t a);
        pending_angles = {pending_angles, a};
    endfunction

    // Send one matrix word after a random gap, then hold it until accepted.
    task automatic send_matrix(logic signed [15:0] m[7]);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {m[6], m[5], m[4], m[3], m[2], m[1], m[0]};
        add_expected(euler_angles(m));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drain the pipe, then write the threshold while nothing is in flight.
    task automatic write_threshold(int unsigned value);
        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= value[14:0];
        @(posedge clk);
        cfg_wen <= 1'b0;
        thr_shadow = value & 32'h7FFF;
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return $signed(16'($urandom()));
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    task automatic test_corners();
        logic signed [15:0] m[7];
        logic signed [15:0] c[6] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd1,
                                     16'sh7FFF, 16'sh8000};
        for (int k = 0; k < 12; k++)
        begin
            foreach (m[j])
                m[j] = c[(k + j) % 6];
            send_matrix(m);
        end
        // Identity, zero, locked (r00 = r10 = 0, both r20 signs), r00 < 0 poses.
        m = '{16'sd16384, 0, 0, 16'sd16384, 0, 0, 16'sd16384};
        send_matrix(m);
        m = '{0, 0, 0, 0, 0, 0, 0};
        send_matrix(m);
        m = '{0, 0, -16'sd16384, 16'sd16384, 0, 0, 0};
        send_matrix(m);
        m = '{0, 0, 16'sd16384, -16'sd9000, 16'sd12000, 0, 0};
        send_matrix(m);
        m = '{-16'sd16384, 0, 0, 16'sd5, -16'sd5, 0, -16'sd3};
        send_matrix(m);
        m = '{-16'sd16384, -16'sd1, 0, 0, 0, -16'sd3, -16'sd3};
        send_matrix(m);
    endtask

    task automatic test_random(int count, int small_sy);
        logic signed [15:0] m[7];
        repeat (count)
        begin
            foreach (m[j])
                m[j] = rand_elem();
            // Push sy near the threshold to exercise the lock decision.
            if (small_sy != 0 && $urandom_range(0, 1) == 1)
            begin
                m[0] = $signed(16'($urandom_range(0, 40))) - 16'sd20;
                m[1] = $signed(16'($urandom_range(0, 40))) - 16'sd20;
            end
            send_matrix(m);
        end
    endtask

    // Receiver: random stall per word, with stretches of no stalling.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 12);
            repeat (stall)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Checker: compare each accepted output word with the oldest prediction.
    always @(posedge clk)
    begin
        angles_t want;
        angles_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[15:0], m_tdata[30:16], m_tdata[46:31], m_tuser};
            if (pending_angles.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_angles.pop_front();
                if (got.yaw !== want.yaw)
                begin
                    $display("%0t: yaw expected %0d actual %0d", $time,
                             $signed(want.yaw), $signed(got.yaw));
                    errors++;
                end
                if (got.pitch !== want.pitch)
                begin
                    $display("%0t: pitch expected %0d actual %0d", $time,
                             $signed(want.pitch), $signed(got.pitch));
                    errors++;
                end
                if (got.roll !== want.roll)
                begin
                    $display("%0t: roll expected %0d actual %0d", $time,
                             $signed(want.roll), $signed(got.roll));
                    errors++;
                end
                if (got.locked !== want.locked)
                begin
                    $display("%0t: gimbal_locked expected %0b actual %0b", $time,
                             want.locked, got.locked);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with words pending and no handshake on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || pending_angles.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        thr_shadow = 1;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        test_random(150, 1);
        write_threshold(0);
        test_corners();
        test_random(120, 0);
        write_threshold(16384);
        test_random(120, 0);
        write_threshold(15);
        test_random(150, 1);
        write_threshold(11585);
        test_random(120, 0);
        write_threshold(32767);
        test_random(40, 0);

        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rmte_pkg.sv
design/rmte_sqrt_cell.sv
design/rmte_cordic_cell.sv
design/rotation_matrix_to_euler_angles_unit.sv
tb/tb.sv
